@@ rtl/bpg_pkg.sv @@
package bpg_pkg;
  localparam int WeightW = 48;
  localparam int SumW    = 56;
  localparam int ProbW   = 16;
  localparam int OpW     = 23;
  localparam int NumW    = 72;
  localparam int ValW    = 16;
  localparam logic [WeightW-1:0] WeightMax = {WeightW{1'b1}};
  localparam logic [WeightW-1:0] WeightOne = 48'h000001000000;

  typedef enum logic [3:0] {
    ST_IDLE, ST_UP_RD, ST_UP_MUL, ST_UP_LO, ST_UP_DIV, ST_DN_RD, ST_DN_MUL, ST_DN_LO,
    ST_DN_DIV, ST_SUM_RD, ST_SUM_ACC, ST_OUT_RD, ST_OUT_DIV
  } state_t;

  typedef struct packed {
    logic            start;
    logic [NumW-1:0] num;
    logic [SumW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [NumW-1:0] quo;
  } div_rsp_t;
endpackage

@@ rtl/bpg_divider.sv @@
module bpg_divider (
  input  logic             clk,
  input  logic             rst,
  input  bpg_pkg::div_req_t req,
  output bpg_pkg::div_rsp_t rsp
);
  localparam int NW = bpg_pkg::NumW;
  localparam int DW = bpg_pkg::SumW;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] quo;
  logic [DW:0]   rem;
  logic [DW-1:0] den;
  logic [CW-1:0] count;
  logic          running;
  logic          done;
  logic [DW:0]   shifted;
  logic [DW+1:0] diff;

  // restoring division, one quotient bit per cycle
  assign shifted = {rem[DW-1:0], quo[NW-1]};
  assign diff    = {1'b0, shifted} - {2'b00, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
        count   <= CW'(NW);
      end else if (running) begin
        count <= count - CW'(1);
        if (count == CW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.num;
      rem <= '0;
      den <= req.den;
    end else if (running) begin
      if (!diff[DW+1]) begin
        rem <= diff[DW:0];
        quo <= {quo[NW-2:0], 1'b1};
      end else begin
        rem <= shifted;
        quo <= {quo[NW-2:0], 1'b0};
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;
endmodule

@@ rtl/binomial_pmf_generator_top.sv @@
// Each weight step uses the shared serial divider, except when its divisor is zero.
// Throughput: one request at a time; busy drops in the cycle of the last point.
// Points leave one at a time, each on the strobe for one cycle; the receiver cannot
// stall. Reset (rst, synchronous) returns the sequencer to idle.
module binomial_pmf_generator_top #(
  parameter int MAX_POINTS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [6:0]  point_count,
  input  logic [5:0]  start_index,
  input  logic [15:0] probability,
  output logic        strobe,
  output logic [5:0]  point_index,
  output logic [15:0] point_value,
  output logic        last_point
);
  localparam int WW = bpg_pkg::WeightW;
  localparam int AW = $clog2(MAX_POINTS);

  bpg_pkg::state_t state, state_next;
  bpg_pkg::div_req_t dreq;
  bpg_pkg::div_rsp_t drsp;

  logic [WW-1:0] mem [MAX_POINTS];
  logic [WW-1:0] rd_data;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [WW-1:0] wr_data;

  logic [6:0]  n;
  logic [6:0]  c;
  logic [6:0]  j;
  logic [16:0] p;
  logic [16:0] q;
  logic [bpg_pkg::SumW-1:0] wsum;
  logic [bpg_pkg::OpW-1:0]  mul_a;
  logic [bpg_pkg::OpW-1:0]  mul_d;
  logic [bpg_pkg::NumW-1:0] prod;
  logic        div_zero;
  logic        sum_zero;
  logic        div_run;
  logic        div_launch;
  logic [23:0] mul_half;
  logic [46:0] part;

  logic [6:0] n_sat;
  logic [6:0] c_sat;
  logic [6:0] j_next;
  logic [6:0] nj;
  logic [bpg_pkg::OpW-1:0] up_a, up_d, dn_a, dn_d;

  assign n_sat = (point_count == 7'd0) ? 7'd1 :
                 (point_count > 7'(MAX_POINTS)) ? 7'(MAX_POINTS) : point_count;
  assign c_sat = ({1'b0, start_index} >= n_sat) ? n_sat - 7'd1 : {1'b0, start_index};

  assign nj   = n - j;
  assign up_a = bpg_pkg::OpW'(nj + 7'd1) * bpg_pkg::OpW'(p);
  assign up_d = bpg_pkg::OpW'(j) * bpg_pkg::OpW'(q);
  assign dn_a = bpg_pkg::OpW'(j) * bpg_pkg::OpW'(q);
  assign dn_d = bpg_pkg::OpW'(nj + 7'd1) * bpg_pkg::OpW'(p);

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  bpg_divider u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  logic [WW-1:0] step_w;
  assign step_w = div_zero ? bpg_pkg::WeightMax :
                  (|drsp.quo[bpg_pkg::NumW-1:WW]) ? bpg_pkg::WeightMax : drsp.quo[WW-1:0];

  // launch the divider once on entry to a divide state whose divisor is nonzero
  assign div_launch = !div_run &&
                      (((state == bpg_pkg::ST_UP_DIV || state == bpg_pkg::ST_DN_DIV) &&
                        !div_zero) ||
                       (state == bpg_pkg::ST_OUT_DIV && !sum_zero));

  always_ff @(posedge clk) begin
    if (rst) div_run <= 1'b0;
    else if ((state != bpg_pkg::ST_UP_DIV && state != bpg_pkg::ST_DN_DIV &&
              state != bpg_pkg::ST_OUT_DIV) || drsp.done) div_run <= 1'b0;
    else if (div_launch) div_run <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= bpg_pkg::ST_IDLE;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= (state == bpg_pkg::ST_OUT_DIV) && drsp.done;
    end
  end

  always_comb begin
    state_next = state;
    rd_addr    = j[AW-1:0];
    wr_en      = 1'b0;
    wr_addr    = j[AW-1:0];
    wr_data    = step_w;
    dreq.start = div_launch;
    dreq.num   = prod;
    dreq.den   = {{(bpg_pkg::SumW-bpg_pkg::OpW){1'b0}}, mul_d};
    j_next     = j;
    unique case (state)
      bpg_pkg::ST_IDLE: begin
        if (start) begin
          wr_en   = 1'b1;
          wr_addr = c_sat[AW-1:0];
          wr_data = bpg_pkg::WeightOne;
          j_next  = c_sat + 7'd1;
          state_next = (c_sat + 7'd1 < n_sat) ? bpg_pkg::ST_UP_RD :
                       (c_sat != 7'd0) ? bpg_pkg::ST_DN_RD : bpg_pkg::ST_SUM_RD;
          if (!(c_sat + 7'd1 < n_sat)) j_next = c_sat;
        end
      end
      bpg_pkg::ST_UP_RD: begin
        rd_addr = AW'(j - 7'd1);
        state_next = bpg_pkg::ST_UP_MUL;
      end
      bpg_pkg::ST_UP_MUL: begin
        // hold the read so the low half is there next cycle
        rd_addr = AW'(j - 7'd1);
        state_next = bpg_pkg::ST_UP_LO;
      end
      bpg_pkg::ST_UP_LO: begin
        state_next = bpg_pkg::ST_UP_DIV;
      end
      bpg_pkg::ST_UP_DIV: begin
        if (drsp.done || div_zero) begin
          wr_en = 1'b1;
          if (j + 7'd1 < n) begin
            j_next = j + 7'd1;
            state_next = bpg_pkg::ST_UP_RD;
          end else if (c != 7'd0) begin
            j_next = c;
            state_next = bpg_pkg::ST_DN_RD;
          end else begin
            j_next = 7'd0;
            state_next = bpg_pkg::ST_SUM_RD;
          end
        end
      end
      bpg_pkg::ST_DN_RD: begin
        state_next = bpg_pkg::ST_DN_MUL;
      end
      bpg_pkg::ST_DN_MUL: begin
        state_next = bpg_pkg::ST_DN_LO;
      end
      bpg_pkg::ST_DN_LO: begin
        state_next = bpg_pkg::ST_DN_DIV;
      end
      bpg_pkg::ST_DN_DIV: begin
        wr_addr = AW'(j - 7'd1);
        if (drsp.done || div_zero) begin
          wr_en = 1'b1;
          if (j > 7'd1) begin
            j_next = j - 7'd1;
            state_next = bpg_pkg::ST_DN_RD;
          end else begin
            j_next = 7'd0;
            state_next = bpg_pkg::ST_SUM_RD;
          end
        end
      end
      bpg_pkg::ST_SUM_RD: begin
        state_next = bpg_pkg::ST_SUM_ACC;
      end
      bpg_pkg::ST_SUM_ACC: begin
        j_next = j + 7'd1;
        if (j + 7'd1 < n) state_next = bpg_pkg::ST_SUM_RD;
        else begin
          j_next = 7'd0;
          state_next = bpg_pkg::ST_OUT_RD;
        end
      end
      bpg_pkg::ST_OUT_RD: begin
        state_next = bpg_pkg::ST_OUT_DIV;
      end
      bpg_pkg::ST_OUT_DIV: begin
        dreq.num = {8'd0, rd_data, 16'd0};
        dreq.den = wsum;
        if (drsp.done || sum_zero) begin
          j_next = j + 7'd1;
          state_next = (j + 7'd1 < n) ? bpg_pkg::ST_OUT_RD : bpg_pkg::ST_IDLE;
        end
      end
      default: state_next = bpg_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == bpg_pkg::ST_IDLE && start) begin
      n <= n_sat;
      c <= c_sat;
      p <= {1'b0, probability};
      q <= 17'h10000 - {1'b0, probability};
      wsum <= '0;
    end
    j <= j_next;
    if (state == bpg_pkg::ST_UP_RD || state == bpg_pkg::ST_DN_RD) begin
      mul_a <= (state == bpg_pkg::ST_UP_RD) ? up_a : dn_a;
      mul_d <= (state == bpg_pkg::ST_UP_RD) ? up_d : dn_d;
    end
    if (state == bpg_pkg::ST_UP_MUL || state == bpg_pkg::ST_DN_MUL) begin
      div_zero <= (mul_d == '0);
    end
    if (state == bpg_pkg::ST_SUM_ACC) wsum <= wsum + {8'd0, rd_data};
    if (state == bpg_pkg::ST_OUT_RD) sum_zero <= (wsum == '0);
    if (state == bpg_pkg::ST_OUT_DIV && (drsp.done || sum_zero)) begin
      point_index <= j[5:0];
      point_value <= sum_zero ? 16'd0 :
                     (|drsp.quo[bpg_pkg::NumW-1:16]) ? 16'hFFFF : drsp.quo[15:0];
      last_point  <= (j + 7'd1 == n);
    end
  end

  // product w*a in the MUL and LO states: high half of w first, then add the low half
  assign mul_half = (state == bpg_pkg::ST_UP_LO || state == bpg_pkg::ST_DN_LO) ?
                    rd_data[23:0] : rd_data[47:24];
  assign part     = 47'(mul_half) * 47'(mul_a);

  always_ff @(posedge clk) begin
    if (state == bpg_pkg::ST_UP_MUL || state == bpg_pkg::ST_DN_MUL)
      prod <= {1'b0, part, 24'd0};
    else if (state == bpg_pkg::ST_UP_LO || state == bpg_pkg::ST_DN_LO)
      prod <= prod + {25'd0, part};
  end

  assign busy = (state != bpg_pkg::ST_IDLE);
endmodule

@@ rtl/bpg_checker.sv @@
module bpg_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        strobe,
  input logic [5:0]  point_index,
  input logic        last_point
);
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("busy not raised");
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_point |-> busy) else $error("point outside run");
  a_first_zero: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> !strobe) else $error("early point");
  a_index_step: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_point |=> !strobe) else $error("back to back points");
  a_top_index_last: assert property (@(posedge clk) disable iff (rst)
    strobe && point_index == 6'd63 |-> last_point) else $error("top index not last");
endmodule

bind binomial_pmf_generator_top bpg_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .strobe(strobe),
  .point_index(point_index), .last_point(last_point)
);
